@@ sv/efd_pkg.sv @@
// ============================================================================
// efd_pkg
// Types and constants shared by the escaped field deframer modules.
// ============================================================================
package efd_pkg;

    localparam int LENGTH_WIDTH_DEFAULT = 16;
    localparam int BYTE_WIDTH           = 8;
    localparam int CAP_WIDTH            = 16;
    localparam int LEN_OUT_WIDTH        = 16;
    localparam int QUEUE_DEPTH          = 4;
    localparam int TDATA_WIDTH          = 24;
    localparam int CFG_INDEX_WIDTH      = 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DELIMITER = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ESCAPE    = 1'b1;

    localparam logic [BYTE_WIDTH-1:0] DELIMITER_RESET = 8'd0;
    localparam logic [BYTE_WIDTH-1:0] ESCAPE_RESET    = 8'd92;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Results of one accepted word: up to two data bytes and an optional field end.
    typedef struct packed {
        logic [1:0]               ndata;
        logic [BYTE_WIDTH-1:0]    byte0;
        logic [BYTE_WIDTH-1:0]    byte1;
        logic                     has_end;
        logic [LEN_OUT_WIDTH-1:0] length;
    } efd_bundle_t;

endpackage

@@ sv/escaped_field_deframer_core.sv @@
// ============================================================================
// escaped_field_deframer_core
// Splits a byte stream into fields at unescaped delimiters, removes escapes.
// ============================================================================
// Each word's results are registered in the queue before the back emits them.
// Throughput: one input word per cycle unless the queue is full; the output
// emits one word per cycle while m_axis_tready is high. A word's k results
// take k output words; a queue of four result bundles absorbs the difference.
// Reset: field state clears, delimiter becomes 0 and escape becomes 92.
module escaped_field_deframer_core
    import efd_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [BYTE_WIDTH-1:0]      cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0: in_byte[7:0], field_capacity[23:8].
    input  logic [TDATA_WIDTH-1:0]     s_axis_tdata,
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // Fields from bit 0: out_byte[7:0], decoded_length[23:8].
    output logic [TDATA_WIDTH-1:0]     m_axis_tdata,
    // Fields from bit 0: item_kind[0].
    output logic                       m_axis_tuser,
    output logic                       m_axis_tlast
);

    logic                     push;
    logic                     pop;
    logic                     full;
    logic                     not_empty;
    efd_bundle_t              push_data;
    efd_bundle_t              head;
    logic [BYTE_WIDTH-1:0]    out_byte;
    logic [LEN_OUT_WIDTH-1:0] out_length;

    efd_front #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata[BYTE_WIDTH-1:0]),
        .in_eob     (s_axis_tlast),
        .in_capacity(s_axis_tdata[BYTE_WIDTH+CAP_WIDTH-1:BYTE_WIDTH]),
        .queue_full (full),
        .in_ready   (s_axis_tready),
        .push       (push),
        .bundle     (push_data)
    );

    efd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .full     (full),
        .not_empty(not_empty),
        .head     (head)
    );

    efd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(not_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_byte  (out_byte),
        .out_length(out_length),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_length, out_byte};

endmodule

@@ sv/efd_front.sv @@
// ============================================================================
// efd_front
// Accepts input words, tracks escape and field state, and builds a bundle of
// results for each word.
// ============================================================================
module efd_front
    import efd_pkg::*;
#(
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [BYTE_WIDTH-1:0]      cfg_data,
    input  logic                       in_valid,
    input  logic [BYTE_WIDTH-1:0]      in_byte,
    input  logic                       in_eob,
    input  logic [CAP_WIDTH-1:0]       in_capacity,
    input  logic                       queue_full,
    output logic                       in_ready,
    output logic                       push,
    output efd_bundle_t                bundle
);

    localparam int CMPW = (LENGTH_WIDTH > CAP_WIDTH) ? LENGTH_WIDTH : CAP_WIDTH;
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};
    localparam logic [CMPW-1:0] LEN_OUT_MAX = CMPW'({LEN_OUT_WIDTH{1'b1}});

    logic [BYTE_WIDTH-1:0]   delim_reg;
    logic [BYTE_WIDTH-1:0]   escape_reg;
    logic                    open_reg;
    logic                    pending_reg;
    logic [LENGTH_WIDTH-1:0] count_reg;
    logic [CAP_WIDTH-1:0]    cap_reg;

    logic                    open_next;
    logic                    pending_next;
    logic [LENGTH_WIDTH-1:0] count_next;
    logic [CAP_WIDTH-1:0]    cap_next;

    logic                    accept;
    logic [CAP_WIDTH-1:0]    cap_eff;
    logic [LENGTH_WIDTH-1:0] c0;
    logic [LENGTH_WIDTH-1:0] c1;
    logic [LENGTH_WIDTH-1:0] c2;
    logic                    pend;
    logic                    is_esc;
    logic                    is_del;
    logic [1:0]              nd;
    logic [BYTE_WIDTH-1:0]   d0;
    logic [BYTE_WIDTH-1:0]   d1;
    logic                    end_hit;
    logic                    set_pending;
    logic                    has_end;
    logic                    emit0;
    logic                    emit1;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cap_eff = open_reg ? cap_reg : in_capacity;
        c0      = open_reg ? count_reg : '0;
        pend    = open_reg && pending_reg;
        is_esc  = (in_byte == escape_reg);
        is_del  = (in_byte == delim_reg);

        nd          = 2'd0;
        d0          = in_byte;
        d1          = in_byte;
        end_hit     = 1'b0;
        set_pending = 1'b0;

        if (pend)
        begin
            if (is_esc || is_del)
            begin
                nd = 2'd1;
            end
            else
            begin
                nd = 2'd2;
                d0 = escape_reg;
            end
        end
        else if (is_esc)
        begin
            if (in_eob)
            begin
                nd = 2'd1;
            end
            else
            begin
                set_pending = 1'b1;
            end
        end
        else if (is_del)
        begin
            end_hit = 1'b1;
        end
        else
        begin
            nd = 2'd1;
        end

        has_end = end_hit || in_eob;

        emit0 = (nd != 2'd0) && (CMPW'(c0) < CMPW'(cap_eff));
        if (nd != 2'd0)
        begin
            c1 = (c0 == LEN_MAX) ? c0 : c0 + 1'b1;
        end
        else
        begin
            c1 = c0;
        end
        emit1 = (nd == 2'd2) && (CMPW'(c1) < CMPW'(cap_eff));
        if (nd == 2'd2)
        begin
            c2 = (c1 == LEN_MAX) ? c1 : c1 + 1'b1;
        end
        else
        begin
            c2 = c1;
        end

        bundle.ndata   = {1'b0, emit0} + {1'b0, emit1};
        bundle.byte0   = d0;
        bundle.byte1   = d1;
        bundle.has_end = has_end;
        bundle.length  = (CMPW'(c2) > LEN_OUT_MAX) ? {LEN_OUT_WIDTH{1'b1}}
                                                    : LEN_OUT_WIDTH'(c2);

        push = accept && (emit0 || has_end);

        open_next    = open_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        cap_next     = cap_reg;
        if (accept)
        begin
            cap_next = cap_eff;
            if (has_end)
            begin
                open_next    = 1'b0;
                pending_next = 1'b0;
                count_next   = '0;
            end
            else
            begin
                open_next    = 1'b1;
                pending_next = set_pending;
                count_next   = c2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg   <= DELIMITER_RESET;
            escape_reg  <= ESCAPE_RESET;
            open_reg    <= 1'b0;
            pending_reg <= 1'b0;
            count_reg   <= '0;
            cap_reg     <= '0;
        end
        else
        begin
            open_reg    <= open_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
            cap_reg     <= cap_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DELIMITER: delim_reg  <= cfg_data;
                    REG_ESCAPE:    escape_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    a_eob_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_eob) |=> !open_reg)
        else $error("field still open after end of buffer");

    a_closed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> (!pending_reg && count_reg == '0))
        else $error("closed field holds escape or count state");

endmodule

@@ sv/efd_queue.sv @@
// ============================================================================
// efd_queue
// Short queue of result bundles between the front and the back.
// ============================================================================
module efd_queue
    import efd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  efd_bundle_t push_data,
    input  logic        pop,
    output logic        full,
    output logic        not_empty,
    output efd_bundle_t head
);

    localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    efd_bundle_t     mem_reg [QUEUE_DEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [CNTW-1:0] count_reg;

    logic [PTRW-1:0] wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_next;
    logic [CNTW-1:0] count_next;

    assign full      = (count_reg == CNTW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

@@ sv/efd_back.sv @@
// ============================================================================
// efd_back
// Walks the head bundle of the queue and emits its results one word at a time.
// ============================================================================
module efd_back
    import efd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  efd_bundle_t            head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_kind,
    output logic [BYTE_WIDTH-1:0]  out_byte,
    output logic [LEN_OUT_WIDTH-1:0] out_length,
    output logic                   out_last
);

    logic [1:0] sel_reg;
    logic [1:0] sel_next;
    logic [1:0] n_total;
    logic       is_data;

    always_comb
    begin
        n_total    = head.ndata + {1'b0, head.has_end};
        is_data    = (sel_reg < head.ndata);
        out_valid  = head_valid;
        out_kind   = is_data ? KIND_DATA : KIND_END;
        out_byte   = is_data ? ((sel_reg == 2'd0) ? head.byte0 : head.byte1) : '0;
        out_length = is_data ? '0 : head.length;
        out_last   = (sel_reg == n_total - 2'd1);
        pop        = head_valid && out_ready && out_last;

        sel_next = sel_reg;
        if (head_valid && out_ready)
        begin
            sel_next = out_last ? 2'd0 : sel_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 2'd0;
        end
        else
        begin
            sel_reg <= sel_next;
        end
    end

    a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (sel_reg < n_total && head.ndata != 2'd3))
        else $error("result index beyond bundle");

    a_sel_resets: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (sel_reg == 2'd0))
        else $error("result index not cleared after bundle");

endmodule

@@ dv/efd_decode_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// efd_decode_checker
// Predicts and checks the decoded output of the escaped field deframer.
// It watches the register port and both stream channels and keeps its own
// copy of the field state. For every accepted input word it queues the data
// bytes and field ends it expects. Each accepted output word is checked
// against the oldest queued result.
// ============================================================================
module efd_decode_checker
    import efd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [BYTE_WIDTH-1:0]      cfg_data,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [TDATA_WIDTH-1:0]     s_axis_tdata,
    input  logic                       s_axis_tlast,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [TDATA_WIDTH-1:0]     m_axis_tdata,
    input  logic                       m_axis_tuser,
    input  logic                       m_axis_tlast,
    output int                         errors,
    output int                         outstanding
);

    typedef struct packed {
        logic                     kind;
        logic [BYTE_WIDTH-1:0]    data;
        logic [LEN_OUT_WIDTH-1:0] length;
        logic                     last;
    } decoded_item_t;

    localparam logic [LEN_OUT_WIDTH-1:0] COUNT_MAX = '1;

    decoded_item_t            expected_items[$];
    decoded_item_t            word_items[$];
    logic [BYTE_WIDTH-1:0]    delim_reg;
    logic [BYTE_WIDTH-1:0]    esc_reg;
    logic                     esc_pending;
    logic                     field_open;
    logic [LEN_OUT_WIDTH-1:0] byte_count;
    logic [CAP_WIDTH-1:0]     capacity;

    task automatic emit_byte(input logic [BYTE_WIDTH-1:0] b);
        decoded_item_t item;
        item = '{KIND_DATA, b, '0, 1'b0};
        if (byte_count < capacity)
            word_items.push_back(item);
        if (byte_count != COUNT_MAX)
            byte_count++;
    endtask

    task automatic close_field();
        decoded_item_t item;
        item = '{KIND_END, '0, byte_count, 1'b0};
        word_items.push_back(item);
        esc_pending = 1'b0;
        byte_count  = '0;
        field_open  = 1'b0;
    endtask

    task automatic decode_word(input logic [BYTE_WIDTH-1:0] b, input logic eob,
                               input logic [CAP_WIDTH-1:0] cap);
        logic ended;
        ended = 1'b0;
        word_items.delete();
        if (!field_open) begin
            capacity    = cap;
            byte_count  = '0;
            esc_pending = 1'b0;
            field_open  = 1'b1;
        end
        if (esc_pending) begin
            esc_pending = 1'b0;
            if (b == esc_reg || b == delim_reg) begin
                emit_byte(b);
            end
            else begin
                emit_byte(esc_reg);
                emit_byte(b);
            end
        end
        else if (b == esc_reg) begin
            if (eob)
                emit_byte(b);
            else
                esc_pending = 1'b1;
        end
        else if (b == delim_reg) begin
            close_field();
            ended = 1'b1;
        end
        else begin
            emit_byte(b);
        end
        if (eob && !ended)
            close_field();
        if (word_items.size() > 0)
            word_items[word_items.size() - 1].last = 1'b1;
        foreach (word_items[i])
            expected_items.push_back(word_items[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decoded_item_t want;
        decoded_item_t got;
        if (!rst_n) begin
            delim_reg   = DELIMITER_RESET;
            esc_reg     = ESCAPE_RESET;
            esc_pending = 1'b0;
            field_open  = 1'b0;
            byte_count  = '0;
            capacity    = '0;
            expected_items.delete();
            errors      = 0;
            outstanding <= 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tlast};
                if (expected_items.size() == 0) begin
                    $display("%0t: unexpected word kind=%0d byte=%02h len=%0d last=%0d",
                             $time, got.kind, got.data, got.length, got.last);
                    errors++;
                end
                else begin
                    want = expected_items.pop_front();
                    if (got != want) begin
                        $display("%0t: expected kind=%0d byte=%02h len=%0d last=%0d, actual kind=%0d byte=%02h len=%0d last=%0d",
                                 $time, want.kind, want.data, want.length, want.last,
                                 got.kind, got.data, got.length, got.last);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_word(s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[23:8]);
            if (cfg_we) begin
                case (cfg_index)
                    REG_DELIMITER: delim_reg = cfg_data;
                    REG_ESCAPE:    esc_reg   = cfg_data;
                    default: ;
                endcase
            end
            outstanding <= expected_items.size();
        end
    end

endmodule

@@ dv/tb_escaped_field_deframer_core.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_escaped_field_deframer_core
// Stimulus and verdict for the escaped field deframer.
// A directed stretch covers escape pairs, capacity limits, trailing escapes,
// delimiters at the end of a buffer and an escape equal to the delimiter.
// Random phases then run under several register settings with random gaps on
// both stream sides.
// ============================================================================
module tb_escaped_field_deframer_core;
    import efd_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_WORDS  = 42;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [BYTE_WIDTH-1:0]      cfg_data = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [TDATA_WIDTH-1:0]     s_axis_tdata = '0;
    logic                       s_axis_tlast = 1'b0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [TDATA_WIDTH-1:0]     m_axis_tdata;
    logic                       m_axis_tuser;
    logic                       m_axis_tlast;

    int   errors;
    int   outstanding;
    int   cycles = 0;
    logic quiet = 1'b0;
    logic [BYTE_WIDTH-1:0] cur_delim = DELIMITER_RESET;
    logic [BYTE_WIDTH-1:0] cur_esc = ESCAPE_RESET;

    escaped_field_deframer_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    efd_decode_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [BYTE_WIDTH-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return cur_esc;
        if (r < 40)
            return cur_delim;
        return BYTE_WIDTH'($urandom_range(0, 255));
    endfunction

    function automatic logic [CAP_WIDTH-1:0] pick_cap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return CAP_WIDTH'($urandom_range(0, 6));
        if (r < 80)
            return CAP_WIDTH'($urandom_range(7, 40));
        if (r < 95)
            return CAP_WIDTH'($urandom_range(0, 65535));
        return '1;
    endfunction

    // Stretches with no idling on either side.
    initial
    begin
        forever
        begin
            quiet <= 1'b0;
            repeat ($urandom_range(200, 600)) @(posedge clk);
            quiet <= 1'b1;
            repeat ($urandom_range(50, 150)) @(posedge clk);
        end
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(0, 12)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    task automatic send_word(input logic [BYTE_WIDTH-1:0] b, input logic eob,
                             input logic [CAP_WIDTH-1:0] cap);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cap, b};
        s_axis_tlast  <= eob;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [BYTE_WIDTH-1:0] value);
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_DELIMITER)
            cur_delim = value;
        else
            cur_esc = value;
    endtask

    task automatic random_phase(input logic [BYTE_WIDTH-1:0] delim,
                                input logic [BYTE_WIDTH-1:0] esc);
        logic [BYTE_WIDTH-1:0] b;
        write_reg(REG_DELIMITER, delim);
        write_reg(REG_ESCAPE, esc);
        for (int i = 0; i < PHASE_WORDS; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                b = BYTE_WIDTH'($urandom_range(0, 255));
            else
                b = pick_byte();
            send_word(b, (i == PHASE_WORDS - 1) || ($urandom_range(0, 19) == 0),
                      pick_cap());
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Capacity limits and a field with capacity zero.
        send_word(8'h41, 1'b0, 16'd3);
        send_word(8'hFF, 1'b0, 16'd0);
        send_word(8'h00, 1'b0, 16'd0);
        send_word(8'h11, 1'b0, 16'd0);
        send_word(8'h12, 1'b0, 16'd9);
        send_word(8'h00, 1'b0, 16'd0);
        // Escape pairs: escaped escape, escaped delimiter, escape before plain byte.
        send_word(8'h5C, 1'b0, 16'hFFFF);
        send_word(8'h5C, 1'b0, 16'd0);
        send_word(8'h5C, 1'b0, 16'd0);
        send_word(8'h00, 1'b0, 16'd0);
        send_word(8'h5C, 1'b0, 16'd0);
        send_word(8'h33, 1'b0, 16'd0);
        send_word(8'h00, 1'b0, 16'd0);
        // An escape pair that straddles the capacity.
        send_word(8'h01, 1'b0, 16'd2);
        send_word(8'h5C, 1'b0, 16'd0);
        send_word(8'h44, 1'b0, 16'd0);
        send_word(8'h55, 1'b1, 16'd0);
        // Trailing escape, delimiter at end of buffer, three results from one word.
        send_word(8'h5C, 1'b1, 16'd5);
        send_word(8'h00, 1'b1, 16'd7);
        send_word(8'h5C, 1'b0, 16'd8);
        send_word(8'h7A, 1'b1, 16'd0);
        // The escape meaning wins when escape and delimiter are equal.
        write_reg(REG_DELIMITER, 8'h7E);
        write_reg(REG_ESCAPE, 8'h7E);
        send_word(8'h7E, 1'b0, 16'd4);
        send_word(8'h7E, 1'b0, 16'd0);
        send_word(8'h7E, 1'b0, 16'd0);
        send_word(8'h10, 1'b0, 16'd0);
        send_word(8'h7E, 1'b1, 16'd0);

        random_phase(8'hFF, 8'h00);
        random_phase(8'h00, 8'hFF);
        random_phase(8'h0A, 8'h0D);
        random_phase(8'h55, 8'h55);
        random_phase(BYTE_WIDTH'($urandom_range(0, 255)),
                     BYTE_WIDTH'($urandom_range(0, 255)));
        random_phase(DELIMITER_RESET, ESCAPE_RESET);

        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
